// ----- rtl/cah_pkg.sv -----
// ----------------------------------------------------------------------------
// cah_pkg - shared definitions for the cascaded average history
// Widths, default ring sizes and operation codes used by every file.
// ----------------------------------------------------------------------------
package cah_pkg;

	localparam int NUM_LEVELS = 4;
	localparam int LVL_W      = 2;
	localparam int MAX_SIZE   = 128;
	localparam int POS_W      = $clog2(MAX_SIZE);
	localparam int SIZE_W     = POS_W + 1;
	localparam int WORD_W     = 16;
	localparam int SUM_W      = WORD_W + POS_W;
	localparam int ADDR_W     = LVL_W + POS_W;
	localparam int AGE_W      = 7;

	localparam int DEF_SIZE_LEVEL0 = 60;
	localparam int DEF_SIZE_LEVEL1 = 60;
	localparam int DEF_SIZE_LEVEL2 = 24;
	localparam int DEF_SIZE_LEVEL3 = 100;
	localparam int DEF_SAMPLE_BITS = 16;

	// operation and result kind codes
	localparam logic OP_ADD     = 1'b0;
	localparam logic OP_READ    = 1'b1;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(NUM_LEVELS - 1);

endpackage

// ----- rtl/cah_div.sv -----
// ----------------------------------------------------------------------------
// cah_div - shared reciprocal divider
// Divides a level's running sum by its ring size with one multiply by a
// per-level reciprocal: a load step, then a multiply step.
// ----------------------------------------------------------------------------
module cah_div
	import cah_pkg::*;
#(
	parameter int SIZE_LEVEL0 = DEF_SIZE_LEVEL0,
	parameter int SIZE_LEVEL1 = DEF_SIZE_LEVEL1,
	parameter int SIZE_LEVEL2 = DEF_SIZE_LEVEL2,
	parameter int SIZE_LEVEL3 = DEF_SIZE_LEVEL3
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LVL_W-1:0]  lvl,
	input  logic [SUM_W-1:0]  dividend,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int SHIFT_W = $clog2(POS_W + 1);

	// ceil(2^(SUM_W + sh) / size); with sh = clog2(size) the floor of
	// dividend * recip >> (SUM_W + sh) is exact for every SUM_W-bit dividend
	function automatic logic [RECIP_W-1:0] recip_of(input int size, input int sh);
		logic [63:0] num;
		num = 64'd1 << (SUM_W + sh);
		return RECIP_W'((num + 64'(size) - 64'd1) / 64'(size));
	endfunction

	localparam logic [SHIFT_W-1:0] SHIFTS [NUM_LEVELS] = '{
		SHIFT_W'($clog2(SIZE_LEVEL0)), SHIFT_W'($clog2(SIZE_LEVEL1)),
		SHIFT_W'($clog2(SIZE_LEVEL2)), SHIFT_W'($clog2(SIZE_LEVEL3))
	};
	localparam logic [RECIP_W-1:0] RECIPS [NUM_LEVELS] = '{
		recip_of(SIZE_LEVEL0, $clog2(SIZE_LEVEL0)),
		recip_of(SIZE_LEVEL1, $clog2(SIZE_LEVEL1)),
		recip_of(SIZE_LEVEL2, $clog2(SIZE_LEVEL2)),
		recip_of(SIZE_LEVEL3, $clog2(SIZE_LEVEL3))
	};

	logic               run_q;
	logic               done_q;
	logic [SUM_W-1:0]   dvd_q;
	logic [RECIP_W-1:0] rcp_q;
	logic [SHIFT_W-1:0] sh_q;
	logic [PROD_W-1:0]  prod_q;
	logic [RECIP_W-1:0] prod_hi;
	logic [RECIP_W-1:0] shifted;

	// load the operands, then multiply by the level's reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			dvd_q  <= '0;
			rcp_q  <= '0;
			sh_q   <= '0;
			prod_q <= '0;
		end else begin
			run_q  <= start;
			done_q <= run_q;
			if (start) begin
				dvd_q <= dividend;
				rcp_q <= RECIPS[lvl];
				sh_q  <= SHIFTS[lvl];
			end
			if (run_q) begin
				prod_q <= {{RECIP_W{1'b0}}, dvd_q} * {{SUM_W{1'b0}}, rcp_q};
			end
		end
	end

	// drop the fraction bits; the mean never exceeds one word
	assign prod_hi  = prod_q[PROD_W-1:SUM_W];
	assign shifted  = prod_hi >> sh_q;
	assign done     = done_q;
	assign quotient = shifted[WORD_W-1:0];

endmodule

// ----- rtl/cah_store.sv -----
// ----------------------------------------------------------------------------
// cah_store - ring entry memory
// One region of MAX_SIZE words per level, one write and one registered read.
// ----------------------------------------------------------------------------
module cah_store
	import cah_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [2**ADDR_W];
	logic [WORD_W-1:0] rdata_q;

	// write an entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read an entry into the output register
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cascaded_average_history.sv -----
// ----------------------------------------------------------------------------
// cascaded_average_history - four-level ring history with block averages
// Samples enter level 0; each time a ring below the last level wraps, the floored
// mean of its entries is written into the next level. Entries can be read back by age.
// ----------------------------------------------------------------------------
// Usage: a word is taken when start is high and busy is low. Results come out
// one per cycle at most, each shown for one cycle with valid high; the
// receiver cannot stall them. An add keeps busy high while it writes each level
// in turn and, after each wrap below the last level, while the shared reciprocal
// divider forms the mean in a load and a multiply step; the worst case is a wrap
// through all four levels. A read stays busy for the registered memory read, an
// out-of-range read not at all. Entries never written read as zero,
// tracked by a per-level fill mark, so no clearing pass follows reset.
module cascaded_average_history
	import cah_pkg::*;
#(
	parameter int SIZE_LEVEL0 = DEF_SIZE_LEVEL0,
	parameter int SIZE_LEVEL1 = DEF_SIZE_LEVEL1,
	parameter int SIZE_LEVEL2 = DEF_SIZE_LEVEL2,
	parameter int SIZE_LEVEL3 = DEF_SIZE_LEVEL3,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [WORD_W-1:0] sample,
	input  logic [LVL_W-1:0]  level,
	input  logic [AGE_W-1:0]  age,
	output logic              valid,
	output logic              kind,
	output logic [LVL_W-1:0]  out_level,
	output logic [WORD_W-1:0] value,
	output logic              error,
	output logic              last
);

	localparam logic [SIZE_W-1:0] SIZES [NUM_LEVELS] = '{
		SIZE_W'(SIZE_LEVEL0), SIZE_W'(SIZE_LEVEL1),
		SIZE_W'(SIZE_LEVEL2), SIZE_W'(SIZE_LEVEL3)
	};
	localparam logic [WORD_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= WORD_W) ?
		{WORD_W{1'b1}} : WORD_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WRITE,
		S_DIV,
		S_READ
	} state_t;

	state_t            state_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [WORD_W-1:0] v_q;
	logic              rd_ok_q;
	logic [POS_W-1:0]  wpos_q [NUM_LEVELS];
	logic              full_q [NUM_LEVELS];
	logic [SUM_W-1:0]  sum_q  [NUM_LEVELS];

	logic              valid_q;
	logic              kind_q;
	logic [LVL_W-1:0]  out_level_q;
	logic [WORD_W-1:0] value_q;
	logic              error_q;
	logic              last_q;

	logic [LVL_W-1:0]  cur_lvl;
	logic [SIZE_W-1:0] cur_size;
	logic [POS_W-1:0]  cur_pos;
	logic              take;
	logic              age_bad;
	logic [SIZE_W-1:0] idx_sum;
	logic [POS_W-1:0]  rd_idx;
	logic              rd_ok;
	logic [SIZE_W-1:0] pos_next;
	logic              wrap;
	logic [SUM_W-1:0]  sum_next;
	logic              div_start;
	logic              div_done;
	logic [WORD_W-1:0] div_quo;
	logic              mem_we;
	logic              mem_re;
	logic [WORD_W-1:0] mem_rdata;

	// select the level being worked on: the request level when idle
	assign cur_lvl  = (state_q == S_IDLE) ? level : lvl_q;
	assign cur_size = SIZES[cur_lvl];
	assign cur_pos  = wpos_q[cur_lvl];
	assign take     = start && (state_q == S_IDLE);

	// locate the entry for a read, oldest first from the write position
	assign age_bad = ({1'b0, age} >= cur_size);
	assign idx_sum = {1'b0, cur_pos} + {1'b0, age};
	assign rd_idx  = (idx_sum >= cur_size) ? POS_W'(idx_sum - cur_size) : POS_W'(idx_sum);
	assign rd_ok   = full_q[cur_lvl] || (rd_idx < cur_pos);

	// advance the write position and accumulate
	assign pos_next  = {1'b0, cur_pos} + 1'b1;
	assign wrap      = (pos_next >= cur_size);
	assign sum_next  = sum_q[cur_lvl] + SUM_W'(v_q);
	assign div_start = (state_q == S_WRITE) && wrap && (lvl_q != LAST_LEVEL);

	assign mem_we = (state_q == S_WRITE);
	assign mem_re = take && (op == OP_READ) && !age_bad;

	cah_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({cur_lvl, cur_pos}),
		.wdata (v_q),
		.re    (mem_re),
		.raddr ({cur_lvl, rd_idx}),
		.rdata (mem_rdata)
	);

	cah_div #(
		.SIZE_LEVEL0 (SIZE_LEVEL0),
		.SIZE_LEVEL1 (SIZE_LEVEL1),
		.SIZE_LEVEL2 (SIZE_LEVEL2),
		.SIZE_LEVEL3 (SIZE_LEVEL3)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.lvl      (lvl_q),
		.dividend (sum_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequence adds and reads, hold level state and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			v_q         <= '0;
			rd_ok_q     <= 1'b0;
			valid_q     <= 1'b0;
			kind_q      <= KIND_WRITE;
			out_level_q <= '0;
			value_q     <= '0;
			error_q     <= 1'b0;
			last_q      <= 1'b0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				wpos_q[i] <= '0;
				full_q[i] <= 1'b0;
				sum_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					valid_q <= take && (op == OP_READ) && age_bad;
					if (take) begin
						if (op == OP_ADD) begin
							lvl_q   <= '0;
							v_q     <= sample & SAMPLE_MASK;
							state_q <= S_WRITE;
						end else if (age_bad) begin
							kind_q      <= KIND_READ;
							out_level_q <= level;
							value_q     <= '0;
							error_q     <= 1'b1;
							last_q      <= 1'b1;
						end else begin
							lvl_q   <= level;
							rd_ok_q <= rd_ok;
							state_q <= S_READ;
						end
					end
				end
				S_WRITE: begin
					valid_q     <= 1'b1;
					kind_q      <= KIND_WRITE;
					out_level_q <= lvl_q;
					value_q     <= v_q;
					error_q     <= 1'b0;
					last_q      <= !wrap || (lvl_q == LAST_LEVEL);
					if (!wrap) begin
						wpos_q[lvl_q] <= POS_W'(pos_next);
						sum_q[lvl_q]  <= sum_next;
						state_q       <= S_IDLE;
					end else begin
						wpos_q[lvl_q] <= '0;
						full_q[lvl_q] <= 1'b1;
						sum_q[lvl_q]  <= '0;
						state_q       <= (lvl_q == LAST_LEVEL) ? S_IDLE : S_DIV;
					end
				end
				S_DIV: begin
					valid_q <= 1'b0;
					if (div_done) begin
						v_q     <= div_quo & SAMPLE_MASK;
						lvl_q   <= lvl_q + 1'b1;
						state_q <= S_WRITE;
					end
				end
				S_READ: begin
					valid_q     <= 1'b1;
					kind_q      <= KIND_READ;
					out_level_q <= lvl_q;
					value_q     <= rd_ok_q ? mem_rdata : '0;
					error_q     <= 1'b0;
					last_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					valid_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign valid     = valid_q;
	assign kind      = kind_q;
	assign out_level = out_level_q;
	assign value     = value_q;
	assign error     = error_q;
	assign last      = last_q;

endmodule

// ----- rtl/cah_checker.sv -----
// ----------------------------------------------------------------------------
// cah_checker - port-level checks for the cascaded average history
// Watches the result word and busy over time; bound to the top level.
// ----------------------------------------------------------------------------
module cah_checker
	import cah_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              valid,
	input logic              kind,
	input logic [WORD_W-1:0] value,
	input logic              error,
	input logic              last
);

	// a read gives exactly one word, so it is always the last one
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_READ) |-> last)
		else $error("read result without last");

	// write words never flag an error
	a_write_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_WRITE) |-> !error)
		else $error("write result with error");

	// an out-of-range read returns zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error |-> (value == '0))
		else $error("error result with nonzero value");

	// the last word leaves the block ready, an earlier one leaves it busy
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == !busy))
		else $error("busy does not match last");

endmodule

bind cascaded_average_history cah_checker u_cah_checker (.*);

// ----- verif/cah_history_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cah_history_checker - result predictor and comparator for the history block
// Watches the command and result channels, keeps its own copy of the four
// rings and accumulators, predicts every result word and compares each one
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cah_history_checker
	import cah_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              op,
	input  logic [WORD_W-1:0] sample,
	input  logic [LVL_W-1:0]  level,
	input  logic [AGE_W-1:0]  age,
	input  logic              valid,
	input  logic              kind,
	input  logic [LVL_W-1:0]  out_level,
	input  logic [WORD_W-1:0] value,
	input  logic              error,
	input  logic              last,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic              kind;
		logic [LVL_W-1:0]  lvl;
		logic [WORD_W-1:0] data;
		logic              err;
		logic              last;
	} history_word_t;

	// shadow copy of the rings, write positions and running sums
	logic [WORD_W-1:0] history_ring [NUM_LEVELS][MAX_SIZE];
	logic [POS_W-1:0]  head_pos [NUM_LEVELS];
	logic [SUM_W-1:0]  level_sum [NUM_LEVELS];

	history_word_t expected_words [$];
	int            mismatches;

	assign fail_count = mismatches;

	function automatic int depth_of(input int lvl);
		case (lvl)
			0:       return DEF_SIZE_LEVEL0;
			1:       return DEF_SIZE_LEVEL1;
			2:       return DEF_SIZE_LEVEL2;
			default: return DEF_SIZE_LEVEL3;
		endcase
	endfunction

	// write a sample into level 0 and cascade floored means upward
	task automatic predict_add(input logic [WORD_W-1:0] smp);
		logic [WORD_W-1:0] v;
		history_word_t     w;
		int                lvl;
		int                len;
		int                p;
		bit                done;
		v    = smp;
		lvl  = 0;
		done = 1'b0;
		while (!done) begin
			len = depth_of(lvl);
			p   = int'(head_pos[lvl]);
			history_ring[lvl][p] = v;
			level_sum[lvl]       = level_sum[lvl] + SUM_W'(v);
			w.kind = KIND_WRITE;
			w.lvl  = LVL_W'(lvl);
			w.data = v;
			w.err  = 1'b0;
			p = p + 1;
			if (p < len) begin
				head_pos[lvl] = POS_W'(p);
				done = 1'b1;
			end else begin
				// wrap: below the last level, the mean of the whole ring moves up one level
				head_pos[lvl]  = '0;
				v              = WORD_W'(level_sum[lvl] / SUM_W'(len));
				level_sum[lvl] = '0;
				if (lvl == NUM_LEVELS - 1)
					done = 1'b1;
				else
					lvl = lvl + 1;
			end
			w.last = done;
			expected_words = {expected_words, w};
		end
	endtask

	// read one entry, oldest first from the write position
	task automatic predict_read(input logic [LVL_W-1:0] lv, input logic [AGE_W-1:0] ag);
		history_word_t w;
		int            len;
		int            idx;
		len    = depth_of(int'(lv));
		w.kind = KIND_READ;
		w.lvl  = lv;
		w.last = 1'b1;
		if (int'(ag) >= len) begin
			w.data = '0;
			w.err  = 1'b1;
		end else begin
			idx = int'(head_pos[lv]) + int'(ag);
			if (idx >= len)
				idx = idx - len;
			w.data = history_ring[lv][idx];
			w.err  = 1'b0;
		end
		expected_words = {expected_words, w};
	endtask

	// compare one result word with the oldest prediction
	task automatic check_result();
		history_word_t w;
		if (expected_words.size() == 0) begin
			$error("unexpected result word: kind %0d level %0d value %0d",
				kind, out_level, value);
			mismatches++;
		end else begin
			w = expected_words.pop_front();
			if (kind !== w.kind) begin
				$error("kind: expected %0d, got %0d", w.kind, kind);
				mismatches++;
			end
			if (out_level !== w.lvl) begin
				$error("out_level: expected %0d, got %0d", w.lvl, out_level);
				mismatches++;
			end
			if (value !== w.data) begin
				$error("value: expected %0d, got %0d", w.data, value);
				mismatches++;
			end
			if (error !== w.err) begin
				$error("error: expected %0d, got %0d", w.err, error);
				mismatches++;
			end
			if (last !== w.last) begin
				$error("last: expected %0d, got %0d", w.last, last);
				mismatches++;
			end
		end
	endtask

	// retire results first, then predict the word taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_pos[l]  = '0;
				level_sum[l] = '0;
				for (int e = 0; e < MAX_SIZE; e++)
					history_ring[l][e] = '0;
			end
			expected_words.delete();
			mismatches = 0;
			pending   <= 0;
		end else begin
			if (valid === 1'b1)
				check_result();
			if (start && !busy) begin
				if (op == OP_ADD)
					predict_add(sample);
				else
					predict_read(level, age);
			end
			pending <= expected_words.size();
		end
	end

endmodule

// ----- verif/cascaded_average_history_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_average_history_test - regression for the cascaded average history
// Drives directed corner words, an add run that wraps level 0 twice into
// level 1, then random add/read words under several sender idle rates.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module cascaded_average_history_test;
	import cah_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int FILL_ADDS   = 2 * DEF_SIZE_LEVEL0;
	localparam int PHASE_WORDS = 60;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              op;
	logic [WORD_W-1:0] sample;
	logic [LVL_W-1:0]  level;
	logic [AGE_W-1:0]  age;
	logic              valid;
	logic              kind;
	logic [LVL_W-1:0]  out_level;
	logic [WORD_W-1:0] value;
	logic              error;
	logic              last;
	int                fail_count;
	int                pending;
	int                cycle_count = 0;

	cascaded_average_history dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.sample    (sample),
		.level     (level),
		.age       (age),
		.valid     (valid),
		.kind      (kind),
		.out_level (out_level),
		.value     (value),
		.error     (error),
		.last      (last)
	);

	cah_history_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.sample     (sample),
		.level      (level),
		.age        (age),
		.valid      (valid),
		.kind       (kind),
		.out_level  (out_level),
		.value      (value),
		.error      (error),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int depth_of(input int lvl);
		case (lvl)
			0:       return DEF_SIZE_LEVEL0;
			1:       return DEF_SIZE_LEVEL1;
			2:       return DEF_SIZE_LEVEL2;
			default: return DEF_SIZE_LEVEL3;
		endcase
	endfunction

	// mix rail values, small values and full random samples
	function automatic logic [WORD_W-1:0] pick_sample();
		case ($urandom_range(3))
			0:       return '1;
			1:       return '0;
			2:       return WORD_W'($urandom);
			default: return WORD_W'($urandom_range(15));
		endcase
	endfunction

	// present one word and hold it until the block takes it
	task automatic send_word(input logic w_op, input logic [WORD_W-1:0] w_sample,
			input logic [LVL_W-1:0] w_level, input logic [AGE_W-1:0] w_age);
		@(negedge clk);
		start  <= 1'b1;
		op     <= w_op;
		sample <= w_sample;
		level  <= w_level;
		age    <= w_age;
		do @(posedge clk); while (busy);
	endtask

	// idle the sender for random cycles, with junk on the payload
	task automatic hold_off(input int pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start  <= 1'b0;
			op     <= 1'($urandom);
			sample <= WORD_W'($urandom);
			level  <= LVL_W'($urandom);
			age    <= AGE_W'($urandom);
		end
	endtask

	// drop start and wait until every predicted word has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// read with ages biased to the edges of the ring
	task automatic random_read();
		int lvl;
		int len;
		int ag;
		lvl = $urandom_range(NUM_LEVELS - 1);
		len = depth_of(lvl);
		case ($urandom_range(9))
			0:       ag = len - 1;
			1:       ag = len;
			2:       ag = $urandom_range((1 << AGE_W) - 1);
			default: ag = $urandom_range(len - 1);
		endcase
		send_word(OP_READ, WORD_W'($urandom), LVL_W'(lvl), AGE_W'(ag));
	endtask

	task automatic random_word(input int pct);
		hold_off(pct);
		if ($urandom_range(99) < 60)
			send_word(OP_ADD, pick_sample(), LVL_W'($urandom), AGE_W'($urandom));
		else
			random_read();
	endtask

	function automatic int idle_for_phase(input int ph);
		case (ph)
			1:       return 81;
			3:       return 9;
			default: return 0;
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int ph;
		arst_n = 1'b0;
		start  = 1'b0;
		op     = OP_ADD;
		sample = '0;
		level  = '0;
		age    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fresh rings read as zero, out-of-range ages flag an error
		send_word(OP_READ, '0, 2'd0, 7'd0);
		send_word(OP_READ, '1, 2'd1, 7'd59);
		send_word(OP_READ, '0, 2'd2, 7'd23);
		send_word(OP_READ, '0, 2'd2, 7'd24);
		send_word(OP_READ, '0, 2'd3, 7'd99);
		send_word(OP_READ, '0, 2'd3, 7'd100);
		send_word(OP_READ, '0, 2'd1, 7'd60);
		send_word(OP_READ, '1, 2'd0, 7'd127);

		// adds ignore level and age; read back newest and oldest
		send_word(OP_ADD, '1, 2'd3, 7'd127);
		send_word(OP_ADD, '0, 2'd2, 7'd64);
		send_word(OP_ADD, 16'h0001, 2'd1, 7'd1);
		send_word(OP_READ, '1, 2'd0, 7'd59);
		send_word(OP_READ, '0, 2'd0, 7'd57);
		send_word(OP_READ, '0, 2'd0, 7'd58);
		drain();

		// wrap level 0 twice so means land in level 1
		for (n = 0; n < FILL_ADDS; n++) begin
			if ($urandom_range(47) == 0)
				random_read();
			send_word(OP_ADD, pick_sample(), LVL_W'($urandom), AGE_W'($urandom));
		end
		send_word(OP_READ, '0, 2'd3, 7'd99);
		send_word(OP_READ, '0, 2'd3, 7'd0);
		send_word(OP_READ, '0, 2'd2, 7'd23);
		send_word(OP_READ, '0, 2'd1, 7'd59);
		drain();

		// random words under each sender idle rate
		for (ph = 0; ph < 4; ph++) begin
			for (n = 0; n < PHASE_WORDS; n++)
				random_word(idle_for_phase(ph));
			drain();
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cah_pkg.sv
rtl/cah_div.sv
rtl/cah_store.sv
rtl/cascaded_average_history.sv
rtl/cah_checker.sv
verif/cah_history_checker.sv
verif/cascaded_average_history_test.sv
